// ----- hdl/bpj_pkg.sv -----
`timescale 1ns / 1ps

package bpj_pkg;

    // Quotient width of every divider
    localparam int QW = 32;

    // Depth-buffer value of 1.0 (fraction over 2^24)
    localparam logic [24:0] RAW_ONE = 25'h1000000;

    // Field and datapath widths
    localparam int RAW_W   = 25;
    localparam int PIX_IN_W = 10;
    localparam int PIX_W   = 12;          // clamped pixel index, up to 4095
    localparam int CFG_W   = 32;
    localparam int CTR_W   = 27;
    localparam int DEN_W   = 56;          // far*(1-d)+near*d, below 2^56
    localparam int NF_W    = 64;          // near*far
    localparam int ZNUM_W  = NF_W + 24;   // near*far*2^24
    localparam int MAG_W   = 28;          // |pix*2^16 - centre|
    localparam int PROD_W  = MAG_W + QW;  // magnitude times depth

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_NEAR     = 3'd0,
        REG_FAR      = 3'd1,
        REG_FOCAL_X  = 3'd2,
        REG_FOCAL_Y  = 3'd3,
        REG_CENTER_X = 3'd4,
        REG_CENTER_Y = 3'd5
    } reg_index_t;

    // Side data carried alongside the depth divider
    typedef struct packed {
        logic             raw_bad;
        logic             den_zero;
        logic [PIX_W-1:0] row;
        logic [PIX_W-1:0] col;
    } depth_side_t;

    // Side data carried alongside the lateral dividers
    typedef struct packed {
        logic          valid;
        logic [QW-1:0] z;
        logic          neg;
        logic          pzero;
    } proj_side_t;

endpackage

// ----- hdl/bpj_div.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, 32-bit quotient
// saturating to all ones. One entry stage plus one stage per quotient bit.
module bpj_div #(
    parameter int NUM_W  = 88,
    parameter int DEN_W  = 56,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [bpj_pkg::QW-1:0] quo,
    output logic [SIDE_W-1:0] side_out
);
    import bpj_pkg::*;

    localparam int HI_W = NUM_W - QW;
    localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [CW-1:0] hi_ext;
    logic [CW-1:0] den_ext;

    logic              vld_reg  [QW+1];
    logic              sat_reg  [QW+1];
    logic [DEN_W-1:0]  rem_reg  [QW+1];
    logic [DEN_W-1:0]  den_reg  [QW+1];
    logic [QW-1:0]     lo_reg   [QW+1];
    logic [QW-1:0]     q_reg    [QW+1];
    logic [SIDE_W-1:0] side_reg [QW+1];

    // Entry: quotient overflows 32 bits when the high part reaches den
    assign hi_ext  = CW'(num[NUM_W-1:QW]);
    assign den_ext = CW'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg[0]  <= (hi_ext >= den_ext);
        rem_reg[0]  <= hi_ext[DEN_W-1:0];
        den_reg[0]  <= den;
        lo_reg[0]   <= num[QW-1:0];
        q_reg[0]    <= '0;
        side_reg[0] <= side_in;
    end

    // One trial subtraction per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[k], lo_reg[k][QW-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign ge    = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sat_reg[k+1]  <= sat_reg[k];
            rem_reg[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            den_reg[k+1]  <= den_reg[k];
            lo_reg[k+1]   <= {lo_reg[k][QW-2:0], 1'b0};
            q_reg[k+1]    <= {q_reg[k][QW-2:0], ge};
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = sat_reg[QW] ? '1 : q_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

// ----- hdl/depth_to_point_backproject_core.sv -----
`timescale 1ns / 1ps

// Depth-buffer to 3-D point back-projection. Takes one pixel per clock: busy
// is always low, so start may be held high every cycle. Each pixel yields one
// result, shown for a single cycle with result_strobe high; the receiver
// cannot hold results off. The pipeline is two 33-stage pipelined dividers in
// series (depth linearisation, then the lateral x/y division by the focal
// lengths) plus six register stages. Configuration registers must be written
// only while no pixel is in flight; the block itself does not enforce this.
module depth_to_point_backproject_core #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [2:0]                    cfg_index,
    input  logic [bpj_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [bpj_pkg::RAW_W-1:0]     depth_sample,
    input  logic [bpj_pkg::PIX_IN_W-1:0]  pixel_row,
    input  logic [bpj_pkg::PIX_IN_W-1:0]  pixel_col,
    output logic                          result_strobe,
    output logic                          point_valid,
    output logic [31:0]                   metric_depth,
    output logic signed [31:0]            point_x,
    output logic signed [31:0]            point_y
);
    import bpj_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] near_reg, far_reg, fx_reg, fy_reg;
    logic [CTR_W-1:0] cx_reg, cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= 32'd6554;
            far_reg  <= 32'd3276800;
            fx_reg   <= 32'd36306944;
            fy_reg   <= 32'd36306944;
            cx_reg   <= 27'd20971520;
            cy_reg   <= 27'd15728640;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_NEAR:     near_reg <= cfg_data;
                REG_FAR:      far_reg  <= cfg_data;
                REG_FOCAL_X:  fx_reg   <= cfg_data;
                REG_FOCAL_Y:  fy_reg   <= cfg_data;
                REG_CENTER_X: cx_reg   <= cfg_data[CTR_W-1:0];
                REG_CENTER_Y: cy_reg   <= cfg_data[CTR_W-1:0];
                default:      ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 0: input beat, pixel indexes clamped
    logic             in_beat;
    logic             s0_vld_reg;
    logic [RAW_W-1:0] s0_raw_reg;
    logic [PIX_W-1:0] s0_row_reg, s0_col_reg;
    logic [PIX_W-1:0] row_next, col_next;

    assign in_beat = start && !busy;

    always_comb
    begin
        row_next = (13'(pixel_row) > 13'(MAX_ROWS - 1)) ? PIX_W'(MAX_ROWS - 1)
                                                        : PIX_W'(pixel_row);
        col_next = (13'(pixel_col) > 13'(MAX_COLUMNS - 1)) ? PIX_W'(MAX_COLUMNS - 1)
                                                           : PIX_W'(pixel_col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else
            s0_vld_reg <= in_beat;
    end

    always_ff @(posedge clk)
    begin
        s0_raw_reg <= depth_sample;
        s0_row_reg <= row_next;
        s0_col_reg <= col_next;
    end

    // Stage 1: the three products of the linearisation
    logic             s1_vld_reg;
    logic             s1_bad_reg;
    logic [DEN_W-1:0] s1_pf_reg, s1_pn_reg;
    logic [NF_W-1:0]  s1_nf_reg;
    logic [PIX_W-1:0] s1_row_reg, s1_col_reg;
    logic [RAW_W-1:0] inv_raw;
    logic [56:0]      pf_full, pn_full;

    assign inv_raw = RAW_ONE - s0_raw_reg;
    assign pf_full = far_reg * inv_raw;
    assign pn_full = near_reg * s0_raw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= s0_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_bad_reg <= (s0_raw_reg >= RAW_ONE);
        s1_pf_reg  <= pf_full[DEN_W-1:0];
        s1_pn_reg  <= pn_full[DEN_W-1:0];
        s1_nf_reg  <= near_reg * far_reg;
        s1_row_reg <= s0_row_reg;
        s1_col_reg <= s0_col_reg;
    end

    // Stage 2: denominator sum
    logic             s2_vld_reg;
    logic [DEN_W-1:0] s2_den_reg;
    logic [NF_W-1:0]  s2_nf_reg;
    depth_side_t      s2_side_reg;
    logic [DEN_W-1:0] den_sum;

    assign den_sum = s1_pf_reg + s1_pn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_den_reg           <= den_sum;
        s2_nf_reg            <= s1_nf_reg;
        s2_side_reg.raw_bad  <= s1_bad_reg;
        s2_side_reg.den_zero <= (den_sum == '0);
        s2_side_reg.row      <= s1_row_reg;
        s2_side_reg.col      <= s1_col_reg;
    end

    // Depth divider
    logic          za_vld;
    logic [QW-1:0] za_quo;
    depth_side_t   za_side;

    bpj_div #(
        .NUM_W  (ZNUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W ($bits(depth_side_t))
    ) u_div_depth (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .num       ({s2_nf_reg, 24'd0}),
        .den       (s2_den_reg),
        .side_in   (s2_side_reg),
        .out_valid (za_vld),
        .quo       (za_quo),
        .side_out  (za_side)
    );

    // Stage 4: depth, validity, offsets from the principal point
    logic             s4_vld_reg, s4_pv_reg, s4_negx_reg, s4_negy_reg;
    logic [QW-1:0]    s4_z_reg;
    logic [MAG_W-1:0] s4_magx_reg, s4_magy_reg;
    logic [QW-1:0]    z_val;
    logic [MAG_W-1:0] pos_x, pos_y, c_x, c_y;
    logic             neg_x, neg_y;

    always_comb
    begin
        z_val = (za_side.raw_bad || za_side.den_zero) ? '0 : za_quo;
        pos_x = {za_side.col, 16'd0};
        pos_y = {za_side.row, 16'd0};
        c_x   = MAG_W'(cx_reg);
        c_y   = MAG_W'(cy_reg);
        neg_x = (c_x > pos_x);
        neg_y = (c_y > pos_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else
            s4_vld_reg <= za_vld;
    end

    always_ff @(posedge clk)
    begin
        s4_z_reg    <= z_val;
        s4_pv_reg   <= (z_val != '0) && (z_val < far_reg);
        s4_negx_reg <= neg_x;
        s4_negy_reg <= neg_y;
        s4_magx_reg <= neg_x ? (c_x - pos_x) : (pos_x - c_x);
        s4_magy_reg <= neg_y ? (c_y - pos_y) : (pos_y - c_y);
    end

    // Stage 5: offset times depth
    logic              s5_vld_reg;
    logic [PROD_W-1:0] s5_px_reg, s5_py_reg;
    proj_side_t        s5_sx_reg, s5_sy_reg;
    logic [PROD_W-1:0] prod_x, prod_y;

    assign prod_x = s4_magx_reg * s4_z_reg;
    assign prod_y = s4_magy_reg * s4_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else
            s5_vld_reg <= s4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_px_reg       <= prod_x;
        s5_py_reg       <= prod_y;
        s5_sx_reg.valid <= s4_pv_reg;
        s5_sx_reg.z     <= s4_z_reg;
        s5_sx_reg.neg   <= s4_negx_reg;
        s5_sx_reg.pzero <= (prod_x == '0);
        s5_sy_reg.valid <= s4_pv_reg;
        s5_sy_reg.z     <= s4_z_reg;
        s5_sy_reg.neg   <= s4_negy_reg;
        s5_sy_reg.pzero <= (prod_y == '0);
    end

    // Lateral dividers; a zero focal length saturates through the divider
    logic          dx_vld, dy_vld;
    logic [QW-1:0] dx_quo, dy_quo;
    proj_side_t    dx_side, dy_side;

    bpj_div #(
        .NUM_W  (PROD_W),
        .DEN_W  (CFG_W),
        .SIDE_W ($bits(proj_side_t))
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_vld_reg),
        .num       (s5_px_reg),
        .den       (fx_reg),
        .side_in   (s5_sx_reg),
        .out_valid (dx_vld),
        .quo       (dx_quo),
        .side_out  (dx_side)
    );

    bpj_div #(
        .NUM_W  (PROD_W),
        .DEN_W  (CFG_W),
        .SIDE_W ($bits(proj_side_t))
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_vld_reg),
        .num       (s5_py_reg),
        .den       (fy_reg),
        .side_in   (s5_sy_reg),
        .out_valid (dy_vld),
        .quo       (dy_quo),
        .side_out  (dy_side)
    );

    // Output stage: clamp to the signed range, apply sign, blank invalid points
    logic        strobe_reg, pv_reg;
    logic [31:0] z_reg, x_reg, y_reg;
    logic [31:0] x_res, y_res;
    logic [32:0] lim_x, lim_y, qx_c, qy_c;

    always_comb
    begin
        lim_x = dx_side.neg ? 33'h080000000 : 33'h07FFFFFFF;
        lim_y = dy_side.neg ? 33'h080000000 : 33'h07FFFFFFF;
        qx_c  = ({1'b0, dx_quo} > lim_x) ? lim_x : {1'b0, dx_quo};
        qy_c  = ({1'b0, dy_quo} > lim_y) ? lim_y : {1'b0, dy_quo};
        x_res = dx_side.neg ? (32'd0 - qx_c[31:0]) : qx_c[31:0];
        y_res = dy_side.neg ? (32'd0 - qy_c[31:0]) : qy_c[31:0];
        if (!dx_side.valid || dx_side.pzero)
            x_res = '0;
        if (!dy_side.valid || dy_side.pzero)
            y_res = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= dx_vld && dy_vld;
    end

    always_ff @(posedge clk)
    begin
        pv_reg <= dx_side.valid;
        z_reg  <= dx_side.z;
        x_reg  <= x_res;
        y_reg  <= y_res;
    end

    assign result_strobe = strobe_reg;
    assign point_valid   = pv_reg;
    assign metric_depth  = z_reg;
    assign point_x       = x_reg;
    assign point_y       = y_reg;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import bpj_pkg::*;

    localparam int LATENCY = 72;

    typedef struct packed {
        logic        valid;
        logic [31:0] depth;
        logic [31:0] px;
        logic [31:0] py;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        start;
    logic        busy;
    logic [24:0] depth_sample;
    logic [9:0]  pixel_row;
    logic [9:0]  pixel_col;
    logic        result_strobe;
    logic        point_valid;
    logic [31:0] metric_depth;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;

    // Shadow copy of the camera registers
    logic [31:0] near_q, far_q, fx_q, fy_q;
    logic [26:0] cx_q, cy_q;

    point_t expected_points[$];
    int     mismatches;
    int     results_seen;

    depth_to_point_backproject_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .depth_sample  (depth_sample),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .result_strobe (result_strobe),
        .point_valid   (point_valid),
        .metric_depth  (metric_depth),
        .point_x       (point_x),
        .point_y       (point_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Depth linearisation: floor(n*f*2^24 / D), saturating
    function automatic logic [31:0] linearise(input logic [24:0] raw);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        if (raw >= RAW_ONE)
            return 32'd0;
        den = 128'(far_q) * (128'(RAW_ONE) - 128'(raw)) + 128'(near_q) * 128'(raw);
        if (den == 0)
            return 32'd0;
        num = (128'(near_q) * 128'(far_q)) << 24;
        q = num / den;
        return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // Lateral coordinate: ((pix<<16) - centre) * z / focal, saturated
    function automatic logic [31:0] lateral(input logic [9:0] pix, input logic [26:0] ctr,
                                            input logic [31:0] z, input logic [31:0] focal);
        logic [63:0]  pos;
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [127:0] q;
        logic [127:0] lim;
        pos = 64'(pix) << 16;
        neg = 64'(ctr) > pos;
        mag = neg ? 64'(ctr) - pos : pos - 64'(ctr);
        prod = 128'(mag) * 128'(z);
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (prod == 0)
            return 32'd0;
        q = (focal == 0) ? lim : prod / 128'(focal);
        if (q > lim)
            q = lim;
        return neg ? (32'd0 - q[31:0]) : q[31:0];
    endfunction

    function automatic point_t backproject(input logic [24:0] raw, input logic [9:0] row,
                                           input logic [9:0] col);
        point_t p;
        p.depth = linearise(raw);
        p.valid = (p.depth > 0) && (p.depth < far_q);
        p.px = p.valid ? lateral(col, cx_q, p.depth, fx_q) : 32'd0;
        p.py = p.valid ? lateral(row, cy_q, p.depth, fy_q) : 32'd0;
        return p;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        point_t exp_p;
        if (rst_n && result_strobe)
        begin
            results_seen++;
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat at %0t", $realtime);
            end
            else
            begin
                exp_p = expected_points.pop_front();
                if (point_valid !== exp_p.valid || metric_depth !== exp_p.depth ||
                    point_x !== exp_p.px || point_y !== exp_p.py)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp v=%0b z=%h x=%h y=%h got v=%0b z=%h x=%h y=%h",
                                 exp_p.valid, exp_p.depth, exp_p.px, exp_p.py,
                                 point_valid, metric_depth, point_x, point_y);
                end
            end
        end
    end

    // Register write, only while the pipeline is empty
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_NEAR:     near_q = value;
            REG_FAR:      far_q  = value;
            REG_FOCAL_X:  fx_q   = value;
            REG_FOCAL_Y:  fy_q   = value;
            REG_CENTER_X: cx_q   = value[26:0];
            default:      cy_q   = value[26:0];
        endcase
    endtask

    task automatic set_camera(input logic [31:0] n, input logic [31:0] f,
                              input logic [31:0] fx, input logic [31:0] fy,
                              input logic [31:0] cx, input logic [31:0] cy);
        write_reg(REG_NEAR, n);
        write_reg(REG_FAR, f);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
    endtask

    // Send one pixel beat; start stays high across back-to-back beats,
    // otherwise it is dropped low after the beat
    task automatic send_pixel(input logic [24:0] raw, input logic [9:0] row,
                              input logic [9:0] col, input bit hold);
        start        <= 1'b1;
        depth_sample <= raw;
        pixel_row    <= row;
        pixel_col    <= col;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_points = {expected_points, backproject(raw, row, col)};
        @(negedge clk);
        if (!hold)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        while (expected_points.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    function automatic logic [24:0] rand_raw;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 25'($urandom_range(16777216, 33554431));
        if (sel == 1)
            return RAW_ONE;
        if (sel <= 4)
            return 25'($urandom_range(16000000, 16777215));
        return 25'($urandom) & 25'hFFFFFF;
    endfunction

    // Bursts of random length with random gaps between them
    task automatic random_pixels(input int count);
        int burst;
        int i;
        i = 0;
        while (i < count)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && i < count)
            begin
                send_pixel(rand_raw(), 10'($urandom), 10'($urandom),
                           burst > 1 && i < count - 1);
                burst--;
                i++;
            end
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 80)) @(negedge clk);
        end
        drain();
    endtask

    task automatic test_directed;
        send_pixel(25'd0, 10'd0, 10'd0, 1);
        send_pixel(25'hFFFFFF, 10'd1023, 10'd1023, 1);
        send_pixel(RAW_ONE, 10'd5, 10'd5, 1);
        send_pixel(25'h1FFFFFF, 10'd300, 10'd400, 0);
        send_pixel(25'h800000, 10'd240, 10'd320, 1);
        send_pixel(25'hFFFFF0, 10'd0, 10'd1023, 1);
        send_pixel(25'hFFF000, 10'd1023, 10'd0, 0);
        drain();
        // extremes of the registers, zero focal lengths
        set_camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'h400_0000);
        send_pixel(25'd0, 10'd0, 10'd0, 1);
        send_pixel(25'h7FFFFF, 10'd1023, 10'd1023, 1);
        send_pixel(25'hFFFFFF, 10'd0, 10'd512, 0);
        drain();
        // zero far plane: zero denominator at raw 0 with zero near
        set_camera(32'd0, 32'd0, 32'd1, 32'd1, 32'h7FF_FFFF, 32'd0);
        send_pixel(25'd0, 10'd3, 10'd3, 1);
        send_pixel(25'h123456, 10'd1023, 10'd1023, 0);
        drain();
        set_camera(32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'h0400_0000);
        send_pixel(25'd0, 10'd1023, 10'd0, 1);
        send_pixel(25'h800000, 10'd0, 10'd1023, 0);
        drain();
    endtask

    task automatic test_random_settings;
        int phase;
        for (phase = 0; phase < 6; phase++)
        begin
            set_camera($urandom_range(1, 32'h2_0000), $urandom_range(32'h1_0000, 32'h100_0000),
                       $urandom, $urandom, $urandom_range(0, 32'h400_0000),
                       $urandom_range(0, 32'h400_0000));
            random_pixels(180);
        end
    endtask

    initial
    begin
        mismatches   = 0;
        results_seen = 0;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_NEAR;
        cfg_data     = '0;
        start        = 1'b0;
        depth_sample = '0;
        pixel_row    = '0;
        pixel_col    = '0;
        near_q = 32'd6554;
        far_q  = 32'd3276800;
        fx_q   = 32'd36306944;
        fy_q   = 32'd36306944;
        cx_q   = 27'd20971520;
        cy_q   = 27'd15728640;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        random_pixels(250);
        test_random_settings();
        if (mismatches == 0 && expected_points.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end
endmodule
